/* src/tssc_pkg.sv */
package tssc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int INDEX_BITS  = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int POS_W       = 16;

    typedef enum logic [3:0] {
        TK_OTHER  = 4'd0,
        TK_IDENT  = 4'd1,
        TK_FUNC   = 4'd2,
        TK_TYPE   = 4'd3,
        TK_RETURN = 4'd4,
        TK_SEMI   = 4'd5,
        TK_LBRACE = 4'd6,
        TK_RBRACE = 4'd7,
        TK_LPAREN = 4'd8,
        TK_RPAREN = 4'd9,
        TK_LBRACK = 4'd10,
        TK_RBRACK = 4'd11
    } t_token;

    typedef enum logic [1:0] {
        BR_PAREN = 2'd0,
        BR_BRACE = 2'd1,
        BR_BRACK = 2'd2
    } t_bracket;

    typedef enum logic [1:0] {
        DECL_IDLE = 2'd0,
        DECL_TYPE = 2'd1,
        DECL_NAME = 2'd2
    } t_decl_stage;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_UNBALANCED = 3'd1,
        ST_NO_PAREN   = 3'd2,
        ST_NO_SEMI    = 3'd3,
        ST_OVERFLOW   = 3'd4
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        t_status          status;
    } t_result;

endpackage

/* src/token_stream_syntax_checker_unit.sv */
// Token stream syntax checker.
// Slave stream: one lexed token class per transaction in s_axis_tdata[3:0],
// s_axis_tlast marks the final token of a stream. Master stream: one status
// transaction per stream, issued for the token that carried tlast.
// A token is taken every cycle while s_axis_tready is high; brackets push or
// pop a row of stack cells that shift together, so the stack top is always in
// the first cell whatever the token's kind.
// The result is registered in the output buffer when the last token is
// accepted. Throughput: one token per cycle while s_axis_tready is high.
// The result sits in an output register backed by one skid entry. Tokens keep
// flowing while a result waits; s_axis_tready drops only when both the output
// register and the skid entry hold results the receiver has not taken.
// Reset clears the stack pointer, all check flags, the token index and both
// output entries; stack cell contents are only read once pushed. After each
// last token the checker clears itself for the next stream.
module token_stream_syntax_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [3:0] token_class, [7:4] zero
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // [2:0] status, [18:3] error_position,
                                          // [23:19] zero
);
    import tssc_pkg::*;

    logic [SP_W-1:0]       r_sp;
    logic                  r_bracket_fault;
    logic                  r_overflow_fault;
    logic                  r_function_waiting;
    logic                  r_function_fault;
    t_decl_stage           r_decl_stage;
    logic                  r_semi_owed;
    logic                  r_semi_fault;
    logic [INDEX_BITS-1:0] r_token_index;
    logic [INDEX_BITS-1:0] r_first_err;

    logic [SP_W-1:0]       n_sp;
    logic                  n_bracket_fault;
    logic                  n_overflow_fault;
    logic                  n_function_waiting;
    logic                  n_function_fault;
    t_decl_stage           n_decl_stage;
    logic                  n_semi_owed;
    logic                  n_semi_fault;
    logic [INDEX_BITS-1:0] n_first_err;

    logic       w_accept;
    logic       w_last;
    logic       w_buf_ready;
    t_token     w_class;
    logic       w_is_open;
    logic       w_is_close;
    logic       w_is_ident;
    logic       w_is_func;
    logic       w_is_type;
    logic       w_is_return;
    logic       w_is_semi;
    logic       w_is_lbrace;
    logic       w_is_lparen;
    t_bracket   w_br_code;
    logic       w_push;
    logic       w_pop;
    logic       w_blocked;
    logic       w_any_prev;
    logic       w_any_now;
    t_stack_ctl w_ctl;
    t_result    w_result;
    t_result    w_out_data;
    logic [POS_W-1:0] w_pos_idx;
    t_bracket   w_cell_code [STACK_DEPTH];

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_last          = i_s_axis_tlast;
    assign w_class         = t_token'(i_s_axis_tdata[3:0]);
    assign o_s_axis_tready = w_buf_ready;

    // class decode; unused codes act as other
    always_comb begin
        w_is_open   = 1'b0;
        w_is_close  = 1'b0;
        w_is_ident  = 1'b0;
        w_is_func   = 1'b0;
        w_is_type   = 1'b0;
        w_is_return = 1'b0;
        w_is_semi   = 1'b0;
        w_is_lbrace = 1'b0;
        w_is_lparen = 1'b0;
        w_br_code   = BR_PAREN;
        unique case (w_class)
            TK_IDENT:  w_is_ident  = 1'b1;
            TK_FUNC:   w_is_func   = 1'b1;
            TK_TYPE:   w_is_type   = 1'b1;
            TK_RETURN: w_is_return = 1'b1;
            TK_SEMI:   w_is_semi   = 1'b1;
            TK_LBRACE: begin
                w_is_open   = 1'b1;
                w_is_lbrace = 1'b1;
                w_br_code   = BR_BRACE;
            end
            TK_RBRACE: begin
                w_is_close = 1'b1;
                w_br_code  = BR_BRACE;
            end
            TK_LPAREN: begin
                w_is_open   = 1'b1;
                w_is_lparen = 1'b1;
                w_br_code   = BR_PAREN;
            end
            TK_RPAREN: begin
                w_is_close = 1'b1;
                w_br_code  = BR_PAREN;
            end
            TK_LBRACK: begin
                w_is_open = 1'b1;
                w_br_code = BR_BRACK;
            end
            TK_RBRACK: begin
                w_is_close = 1'b1;
                w_br_code  = BR_BRACK;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_sp               = r_sp;
        n_bracket_fault    = r_bracket_fault;
        n_overflow_fault   = r_overflow_fault;
        w_push             = 1'b0;
        w_pop              = 1'b0;
        w_blocked          = r_bracket_fault || r_overflow_fault;

        // bracket stack
        if (!w_blocked && w_is_open) begin
            if (r_sp == SP_W'(STACK_DEPTH)) begin
                n_overflow_fault = 1'b1;
            end else begin
                w_push = 1'b1;
                n_sp   = r_sp + SP_W'(1);
            end
        end
        if (!w_blocked && w_is_close) begin
            if (r_sp == '0) begin
                n_bracket_fault = 1'b1;
            end else begin
                w_pop = 1'b1;
                n_sp  = r_sp - SP_W'(1);
                if (w_cell_code[0] != w_br_code) begin
                    n_bracket_fault = 1'b1;
                end
            end
        end

        // function must be followed by an open paren
        n_function_fault   = r_function_fault || (r_function_waiting && !w_is_lparen);
        n_function_waiting = w_is_func;

        // semicolon obligations
        n_semi_owed  = r_semi_owed;
        n_decl_stage = r_decl_stage;
        n_semi_fault = r_semi_fault;
        if (w_is_semi) begin
            n_semi_owed  = 1'b0;
            n_decl_stage = DECL_IDLE;
        end else if (w_is_lbrace) begin
            if (r_semi_owed || r_decl_stage != DECL_IDLE) begin
                n_semi_fault = 1'b1;
            end
            n_semi_owed  = 1'b0;
            n_decl_stage = DECL_IDLE;
        end else begin
            if (r_decl_stage == DECL_TYPE) begin
                if (w_is_ident) begin
                    n_decl_stage = DECL_NAME;
                end else begin
                    n_semi_owed  = 1'b1;
                    n_decl_stage = DECL_IDLE;
                end
            end else if (r_decl_stage == DECL_NAME) begin
                if (!w_is_lparen) begin
                    n_semi_owed = 1'b1;
                end
                n_decl_stage = DECL_IDLE;
            end
            if (w_is_type) begin
                n_decl_stage = DECL_TYPE;
            end else if (w_is_return) begin
                n_semi_owed = 1'b1;
            end
        end

        // end-of-stream checks
        if (w_last) begin
            if (!n_bracket_fault && !n_overflow_fault && n_sp != '0) begin
                n_bracket_fault = 1'b1;
            end
            if (n_function_waiting) begin
                n_function_fault = 1'b1;
            end
            if (n_semi_owed || n_decl_stage != DECL_IDLE) begin
                n_semi_fault = 1'b1;
            end
        end

        w_any_prev = r_bracket_fault || r_overflow_fault || r_function_fault
                     || r_semi_fault;
        w_any_now  = n_bracket_fault || n_overflow_fault || n_function_fault
                     || n_semi_fault;
        n_first_err = (!w_any_prev && w_any_now) ? r_token_index : r_first_err;

        w_ctl.push = w_accept && w_push;
        w_ctl.pop  = w_accept && w_pop;
    end

    generate
        if (INDEX_BITS >= POS_W) begin : g_pos_trunc
            assign w_pos_idx = n_first_err[POS_W-1:0];
        end else begin : g_pos_ext
            assign w_pos_idx = {{(POS_W-INDEX_BITS){1'b0}}, n_first_err};
        end
    endgenerate

    always_comb begin
        if (n_overflow_fault) begin
            w_result.status = ST_OVERFLOW;
        end else if (n_bracket_fault) begin
            w_result.status = ST_UNBALANCED;
        end else if (n_function_fault) begin
            w_result.status = ST_NO_PAREN;
        end else if (n_semi_fault) begin
            w_result.status = ST_NO_SEMI;
        end else begin
            w_result.status = ST_OK;
        end
        w_result.pos = (w_result.status != ST_OK) ? w_pos_idx : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && w_last)) begin
            r_sp               <= '0;
            r_bracket_fault    <= 1'b0;
            r_overflow_fault   <= 1'b0;
            r_function_waiting <= 1'b0;
            r_function_fault   <= 1'b0;
            r_decl_stage       <= DECL_IDLE;
            r_semi_owed        <= 1'b0;
            r_semi_fault       <= 1'b0;
            r_token_index      <= '0;
            r_first_err        <= '0;
        end else if (w_accept) begin
            r_sp               <= n_sp;
            r_bracket_fault    <= n_bracket_fault;
            r_overflow_fault   <= n_overflow_fault;
            r_function_waiting <= n_function_waiting;
            r_function_fault   <= n_function_fault;
            r_decl_stage       <= n_decl_stage;
            r_semi_owed        <= n_semi_owed;
            r_semi_fault       <= n_semi_fault;
            r_token_index      <= r_token_index + INDEX_BITS'(1);
            r_first_err        <= n_first_err;
        end
    end

    // stack cells: cell 0 holds the top
    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            t_bracket w_above;
            t_bracket w_below;
            if (g == 0) begin : g_head
                assign w_above = w_br_code;
            end else begin : g_body
                assign w_above = w_cell_code[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_tail
                assign w_below = w_cell_code[g];
            end else begin : g_inner
                assign w_below = w_cell_code[g+1];
            end
            tssc_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_from_above (w_above),
                .i_from_below (w_below),
                .o_code       (w_cell_code[g])
            );
        end
    endgenerate

    tssc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept && w_last),
        .i_data  (w_result),
        .o_ready (w_buf_ready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_out_data),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {5'b0, w_out_data};

`ifndef SYNTHESIS
    a_sp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow_fault |-> (r_sp == SP_W'(STACK_DEPTH)))
        else $error("overflow flagged with room on stack");
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_sp == '0 && r_token_index == '0 && !r_semi_owed))
        else $error("state not cleared after last token");
    a_ok_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[2:0] == ST_OK) |-> o_m_axis_tdata[18:3] == '0)
        else $error("ok status with nonzero position");
`endif

endmodule

/* src/tssc_cell.sv */
module tssc_cell (
    input  logic               i_clk,
    input  tssc_pkg::t_stack_ctl i_ctl,
    input  tssc_pkg::t_bracket i_from_above,
    input  tssc_pkg::t_bracket i_from_below,
    output tssc_pkg::t_bracket o_code
);
    import tssc_pkg::*;

    t_bracket r_code;

    // push moves every entry one cell deeper, pop pulls them one cell up
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_code <= i_from_above;
        end else if (i_ctl.pop) begin
            r_code <= i_from_below;
        end
    end

    assign o_code = r_code;

endmodule

/* src/tssc_out_buf.sv */
module tssc_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tssc_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    output tssc_pkg::t_result o_data,
    input  logic              i_ready
);
    import tssc_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    w_drain;

    assign w_drain = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                // refill output from skid once the receiver takes the head
                if (w_drain) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (!r_out_valid || w_drain) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_drain) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_drain) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_drain) begin
                r_out_data <= i_data;
            end else begin
                r_skid_data <= i_data;
            end
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");
    a_push_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_out_valid && !i_ready) |=> r_skid_valid)
        else $error("result lost while output stalled");
    a_drain_moves_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_drain) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not advanced on drain");
`endif

endmodule
